>>> rtl/core/vdrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdrt_pkg
// Shared constants and controller/datapath interface types for the VRAM
// dirty rectangle tracker.
// ----------------------------------------------------------------------------
package vdrt_pkg;

   localparam int ADDR_W  = 20;
   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int TOTAL_W = 5;
   localparam int COORD_W = 21;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_PEEK  = 2'd2;

   localparam logic [SIZE_W-1:0] MAX_SIZE = 3'd4;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic rd_step;
      logic wr_step;
      logic div_start;
      logic div_load;
      logic piece_setup;
      logic walk_issue;
      logic walk_cmp;
      logic append;
      logic collapse;
      logic advance;
      logic peek_issue;
      logic peek_cap;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       clear_done;
      logic       rd_busy;
      logic       wr_busy;
      logic       n_zero;
      logic       div_busy;
      logic       len_zero;
      logic       walk_end;
      logic       full;
      logic       hit;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/vdrt_vram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdrt_vram
// Byte-wide video memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vdrt_vram #(
   parameter int VRAM_BYTES = 1048576,
   parameter int AW         = 20
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);

   logic [7:0] mem [VRAM_BYTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> rtl/core/vdrt_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdrt_divider
// Restoring divider, one quotient bit per cycle, for address / stride.
// ----------------------------------------------------------------------------
module vdrt_divider #(
   parameter int W = 21
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [vdrt_pkg::ADDR_W-1:0] dividend,
   input  wire logic [W-1:0]              divisor,
   output logic                           busy,
   output logic [vdrt_pkg::ADDR_W-1:0]    quot,
   output logic [W-1:0]                   rem
);
   import vdrt_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W:0]        trial;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, q_ff[ADDR_W-1]};
      if (start) begin
         cnt_in  = CNT_W'(ADDR_W);
         busy_in = 1'b1;
         q_in    = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = W'(trial - {1'b0, divisor});
            q_in   = {q_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

>>> rtl/core/vdrt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdrt_datapath
// Item registers, VRAM access, row piece splitting, dirty slot memory and
// the result register.
// ----------------------------------------------------------------------------
module vdrt_datapath #(
   parameter int VRAM_BYTES  = 1048576,
   parameter int DIRTY_SLOTS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire vdrt_pkg::cmd_type            cmd,
   output vdrt_pkg::status_type              st,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [vdrt_pkg::ADDR_W-1:0]  req_address,
   input  wire logic [vdrt_pkg::SIZE_W-1:0]  req_access_size,
   input  wire logic [vdrt_pkg::DATA_W-1:0]  req_write_data,
   input  wire logic [vdrt_pkg::SLOT_W-1:0]  req_slot_index,
   input  wire logic                         csr_write_enable,
   input  wire logic [vdrt_pkg::COORD_W-1:0] csr_write_data,
   output logic [vdrt_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [vdrt_pkg::TOTAL_W-1:0]      rsp_dirty_total,
   output logic [vdrt_pkg::COORD_W-1:0]      rsp_rect_left,
   output logic [vdrt_pkg::COORD_W-1:0]      rsp_rect_top,
   output logic [vdrt_pkg::COORD_W-1:0]      rsp_rect_right,
   output logic [vdrt_pkg::COORD_W-1:0]      rsp_rect_bottom
);
   import vdrt_pkg::*;

   localparam int VB_W = $clog2(VRAM_BYTES + 1);
   localparam int CW   = (VB_W > COORD_W) ? VB_W : COORD_W;
   localparam int AW   = (VRAM_BYTES > 1) ? $clog2(VRAM_BYTES) : 1;
   localparam int CNTW = $clog2(DIRTY_SLOTS + 1);
   localparam int SIW  = (DIRTY_SLOTS > 1) ? $clog2(DIRTY_SLOTS) : 1;
   localparam int PW   = (CNTW > SLOT_W) ? CNTW : SLOT_W;
   localparam int TW   = (CNTW > TOTAL_W) ? CNTW : TOTAL_W;

   localparam logic [CW-1:0]   VRAM_END  = CW'(VRAM_BYTES);
   localparam logic [CW-1:0]   CLEAR_END = CW'(VRAM_BYTES - 1);
   localparam logic [CNTW-1:0] SLOTS_MAX = CNTW'(DIRTY_SLOTS);

   // item registers
   logic [1:0]        op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SIZE_W-1:0] sz_ff, n_ff, i_ff, len_ff, take_ff;
   logic [DATA_W-1:0] wdata_ff, rd_acc_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              pend_ff, pend_inr_ff;
   logic [COORD_W-1:0] stride_ff;
   logic [CW-1:0]     clr_ff, col_ff, row_ff;
   logic [CW-1:0]     stride_eff;
   logic [3:0][CW-1:0] rect_ff, bbox_ff, pk_ff;
   logic [CNTW-1:0]   k_ff, count_ff;

   // result register
   logic [DATA_W-1:0]  out_rd_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic [3:0][COORD_W-1:0] out_rect_ff;

   // slot memory, entry order left, top, right, bottom
   logic [3:0][CW-1:0] slot_mem [DIRTY_SLOTS];
   logic [3:0][CW-1:0] slot_rd, slot_wd;
   logic               slot_we;
   logic [SIW-1:0]     slot_wa, slot_ra;

   logic [SIZE_W-1:0] size_clamp, n_calc, bsel, take_c;
   logic [CW-1:0]     byte_addr, room, col_sum;
   logic              byte_inr;
   logic [PW-1:0]     slot_ext, count_ext;
   logic [TW-1:0]     total_ext;
   logic              hit;

   logic              vram_we;
   logic [AW-1:0]     vram_wa, vram_ra;
   logic [7:0]        vram_wd, vram_rd;
   logic [ADDR_W-1:0] div_q;
   logic [CW-1:0]     div_r;
   logic              div_busy;

   assign stride_eff = (stride_ff == '0) ? VRAM_END : CW'(stride_ff);
   assign size_clamp = (req_access_size > MAX_SIZE) ? MAX_SIZE : req_access_size;

   // in-range bytes form a prefix of the access
   always_comb begin
      n_calc = '0;
      for (int j = 0; j < 4; j++) begin
         if ((SIZE_W'(j) < size_clamp) &&
             ((CW'(req_address) + CW'(j)) < VRAM_END)) begin
            n_calc = n_calc + 1'b1;
         end
      end
   end

   assign byte_addr = CW'(addr_ff) + CW'(i_ff);
   assign byte_inr  = byte_addr < VRAM_END;
   assign bsel      = sz_ff - 3'd1 - i_ff;

   assign room    = stride_eff - col_ff;
   assign take_c  = (room < CW'(len_ff)) ? room[SIZE_W-1:0] : len_ff;
   assign col_sum = col_ff + CW'(take_ff);

   assign hit = (slot_rd[0] < rect_ff[2]) && (slot_rd[2] > rect_ff[0]) &&
                (slot_rd[1] < rect_ff[3]) && (slot_rd[3] > rect_ff[1]);

   assign slot_ext  = PW'(slot_ff);
   assign count_ext = PW'(count_ff);
   assign total_ext = TW'(count_ff);

   // vram port muxing
   always_comb begin
      vram_we = 1'b0;
      vram_wa = byte_addr[AW-1:0];
      vram_wd = wdata_ff[{bsel[1:0], 3'b000} +: 8];
      if (cmd.clear_step) begin
         vram_we = 1'b1;
         vram_wa = clr_ff[AW-1:0];
         vram_wd = '0;
      end else if (cmd.wr_step && (i_ff < sz_ff) && byte_inr) begin
         vram_we = 1'b1;
      end
   end
   assign vram_ra = byte_addr[AW-1:0];

   vdrt_vram #(
      .VRAM_BYTES(VRAM_BYTES),
      .AW        (AW)
   ) u_vram (
      .clock(clock),
      .we   (vram_we),
      .waddr(vram_wa),
      .wdata(vram_wd),
      .raddr(vram_ra),
      .rdata(vram_rd)
   );

   vdrt_divider #(
      .W(CW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(addr_ff),
      .divisor (stride_eff),
      .busy    (div_busy),
      .quot    (div_q),
      .rem     (div_r)
   );

   // slot memory write sources
   always_comb begin
      slot_we = 1'b0;
      slot_wa = k_ff[SIW-1:0];
      slot_wd = rect_ff;
      if (cmd.walk_cmp && hit) begin
         slot_we    = 1'b1;
         slot_wd[0] = (rect_ff[0] < slot_rd[0]) ? rect_ff[0] : slot_rd[0];
         slot_wd[1] = (rect_ff[1] < slot_rd[1]) ? rect_ff[1] : slot_rd[1];
         slot_wd[2] = (rect_ff[2] > slot_rd[2]) ? rect_ff[2] : slot_rd[2];
         slot_wd[3] = (rect_ff[3] > slot_rd[3]) ? rect_ff[3] : slot_rd[3];
      end else if (cmd.append) begin
         slot_we = 1'b1;
         slot_wa = count_ff[SIW-1:0];
      end else if (cmd.collapse) begin
         slot_we = 1'b1;
         slot_wa = '0;
         slot_wd = bbox_ff;
      end
   end
   assign slot_ra = cmd.peek_issue ? slot_ext[SIW-1:0] : k_ff[SIW-1:0];

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd <= slot_mem[slot_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= '0;
         count_ff  <= '0;
         clr_ff    <= '0;
         i_ff      <= '0;
         pend_ff   <= 1'b0;
         k_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            stride_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load) begin
            i_ff    <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.rd_step) begin
            pend_ff <= i_ff < sz_ff;
            if (i_ff < sz_ff) begin
               i_ff <= i_ff + 1'b1;
            end
         end else if (cmd.wr_step && (i_ff < sz_ff)) begin
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.piece_setup) begin
            k_ff <= '0;
         end else if (cmd.walk_cmp && !hit) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.append) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.collapse) begin
            count_ff <= CNTW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         addr_ff   <= req_address;
         sz_ff     <= size_clamp;
         n_ff      <= n_calc;
         wdata_ff  <= req_write_data;
         slot_ff   <= req_slot_index;
         rd_acc_ff <= '0;
         pk_ff     <= '0;
      end
      if (cmd.rd_step) begin
         pend_inr_ff <= byte_inr;
         if (pend_ff) begin
            rd_acc_ff <= {rd_acc_ff[DATA_W-9:0], pend_inr_ff ? vram_rd : 8'h00};
         end
      end
      if (cmd.div_load) begin
         col_ff <= div_r;
         row_ff <= CW'(div_q);
         len_ff <= n_ff;
      end
      if (cmd.piece_setup) begin
         take_ff    <= take_c;
         rect_ff[0] <= col_ff;
         rect_ff[1] <= row_ff;
         rect_ff[2] <= col_ff + CW'(take_c);
         rect_ff[3] <= row_ff + 1'b1;
         bbox_ff[0] <= col_ff;
         bbox_ff[1] <= row_ff;
         bbox_ff[2] <= col_ff + CW'(take_c);
         bbox_ff[3] <= row_ff + 1'b1;
      end
      if (cmd.walk_cmp && !hit) begin
         if (slot_rd[0] < bbox_ff[0]) bbox_ff[0] <= slot_rd[0];
         if (slot_rd[1] < bbox_ff[1]) bbox_ff[1] <= slot_rd[1];
         if (slot_rd[2] > bbox_ff[2]) bbox_ff[2] <= slot_rd[2];
         if (slot_rd[3] > bbox_ff[3]) bbox_ff[3] <= slot_rd[3];
      end
      if (cmd.advance) begin
         len_ff <= len_ff - take_ff;
         if (col_sum == stride_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            col_ff <= col_sum;
         end
      end
      if (cmd.peek_cap && (slot_ext < count_ext)) begin
         pk_ff <= slot_rd;
      end
      if (cmd.out_load) begin
         out_rd_ff    <= rd_acc_ff;
         out_total_ff <= total_ext[TOTAL_W-1:0];
         for (int j = 0; j < 4; j++) begin
            out_rect_ff[j] <= pk_ff[j][COORD_W-1:0];
         end
      end
   end

   always_comb begin
      st            = '0;
      st.op         = op_ff;
      st.clear_done = clr_ff == CLEAR_END;
      st.rd_busy    = (i_ff < sz_ff) || pend_ff;
      st.wr_busy    = i_ff < sz_ff;
      st.n_zero     = n_ff == '0;
      st.div_busy   = div_busy;
      st.len_zero   = len_ff == '0;
      st.walk_end   = k_ff == count_ff;
      st.full       = count_ff == SLOTS_MAX;
      st.hit        = hit;
   end

   assign rsp_read_data   = out_rd_ff;
   assign rsp_dirty_total = out_total_ff;
   assign rsp_rect_left   = out_rect_ff[0];
   assign rsp_rect_top    = out_rect_ff[1];
   assign rsp_rect_right  = out_rect_ff[2];
   assign rsp_rect_bottom = out_rect_ff[3];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_MAX)
      else $error("dirty slot count above capacity");

   a_collapse: assert property (@(posedge clock) disable iff (reset)
      cmd.collapse |=> count_ff == CNTW'(1))
      else $error("collapse did not leave one slot");

   a_append: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the list by one");

endmodule
`default_nettype wire

>>> rtl/core/vdrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdrt_ctrl
// Sequencer for the tracker: clearing pass, byte loops, divide, slot walk,
// slot peek and result handoff.
// ----------------------------------------------------------------------------
module vdrt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire vdrt_pkg::status_type st,
   output vdrt_pkg::cmd_type         cmd
);
   import vdrt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_READ, S_WRITE, S_DIV_GO, S_DIV_WAIT,
      S_PIECE, S_WALK_RD, S_WALK_CMP, S_PEEK_RD, S_PEEK_CAP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (st.op)
               OP_READ:  state_in = S_READ;
               OP_WRITE: state_in = S_WRITE;
               OP_PEEK:  state_in = S_PEEK_RD;
               default:  state_in = S_DONE;
            endcase
         end
         S_READ: begin
            cmd.rd_step = 1'b1;
            if (!st.rd_busy) state_in = S_DONE;
         end
         S_WRITE: begin
            cmd.wr_step = 1'b1;
            if (!st.wr_busy) state_in = st.n_zero ? S_DONE : S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!st.div_busy) begin
               cmd.div_load = 1'b1;
               state_in     = S_PIECE;
            end
         end
         S_PIECE: begin
            if (st.len_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.piece_setup = 1'b1;
               state_in        = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            if (st.walk_end) begin
               // no overlap found: append, or fold everything into slot 0
               cmd.append   = !st.full;
               cmd.collapse = st.full;
               cmd.advance  = 1'b1;
               state_in     = S_PIECE;
            end else begin
               cmd.walk_issue = 1'b1;
               state_in       = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            cmd.walk_cmp = 1'b1;
            if (st.hit) begin
               cmd.advance = 1'b1;
               state_in    = S_PIECE;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_PEEK_RD: begin
            cmd.peek_issue = 1'b1;
            state_in       = S_PEEK_CAP;
         end
         S_PEEK_CAP: begin
            cmd.peek_cap = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before taken");

endmodule
`default_nettype wire

>>> rtl/core/vram_dirty_rect_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vram_dirty_rect_tracker
// Byte-addressed VRAM with dirty rectangle tracking.
//
// Request channel (req_*): opcode read, write or peek, with address, size
// (0..4 bytes, 5..7 taken as 4, big-endian), write data and slot index.
// One rsp_* response per request: read data, dirty slot count, peeked slot.
// csr_write_enable/csr_write_data set the row stride (0 = one row).
// After reset a clearing pass zeroes the VRAM one byte per cycle, with
// req_ready low. One item at a time, accept to result register: a read
// or write steps through its bytes, a peek reads the chosen slot, an
// unused opcode goes straight to the result. A write with bytes in range
// then divides the address by the stride and, per row piece, walks the
// slot list to merge into the first overlapping slot, else appends or,
// when the list is full, collapses it into slot 0.
// The result waits in an output register; a stalled receiver does not
// block acceptance of the next transaction, only the handoff of its result.
// ----------------------------------------------------------------------------
module vram_dirty_rect_tracker #(
   parameter int VRAM_BYTES  = 1048576,
   parameter int DIRTY_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [19:0] req_address,
   input  wire logic [2:0]  req_access_size,
   input  wire logic [31:0] req_write_data,
   input  wire logic [3:0]  req_slot_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic [4:0]       rsp_dirty_total,
   output logic [20:0]      rsp_rect_left,
   output logic [20:0]      rsp_rect_top,
   output logic [20:0]      rsp_rect_right,
   output logic [20:0]      rsp_rect_bottom,
   input  wire logic        csr_write_enable,
   input  wire logic [20:0] csr_write_data
);
   import vdrt_pkg::*;

   cmd_type    cmd;
   status_type st;

   vdrt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .st       (st),
      .cmd      (cmd)
   );

   vdrt_datapath #(
      .VRAM_BYTES (VRAM_BYTES),
      .DIRTY_SLOTS(DIRTY_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_opcode      (req_opcode),
      .req_address     (req_address),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .req_slot_index  (req_slot_index),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_read_data   (rsp_read_data),
      .rsp_dirty_total (rsp_dirty_total),
      .rsp_rect_left   (rsp_rect_left),
      .rsp_rect_top    (rsp_rect_top),
      .rsp_rect_right  (rsp_rect_right),
      .rsp_rect_bottom (rsp_rect_bottom)
   );

endmodule
`default_nettype wire

>>> bench/vram_dirty_rect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vram_dirty_rect_checker
// Watches the request, response and csr ports of the dirty rectangle
// tracker, predicts every response from its own VRAM and slot list copy,
// and compares each response field by field in order.
// ----------------------------------------------------------------------------
module vram_dirty_rect_checker #(
   parameter int VRAM_BYTES  = 1048576,
   parameter int DIRTY_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [19:0] req_address,
   input  logic [2:0]  req_access_size,
   input  logic [31:0] req_write_data,
   input  logic [3:0]  req_slot_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic [4:0]  rsp_dirty_total,
   input  logic [20:0] rsp_rect_left,
   input  logic [20:0] rsp_rect_top,
   input  logic [20:0] rsp_rect_right,
   input  logic [20:0] rsp_rect_bottom,
   input  logic        csr_write_enable,
   input  logic [20:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   import vdrt_pkg::*;

   typedef struct packed {
      logic [31:0]        read_data;
      logic [4:0]         dirty_total;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } vram_rsp_type;

   logic [7:0]   vram_shadow [int];
   int unsigned  rect_l [DIRTY_SLOTS];
   int unsigned  rect_t [DIRTY_SLOTS];
   int unsigned  rect_r [DIRTY_SLOTS];
   int unsigned  rect_b [DIRTY_SLOTS];
   int unsigned  rect_count;
   int unsigned  stride_reg;
   vram_rsp_type expected_rsp [$];

   function automatic logic [7:0] vram_byte(int unsigned a);
      if (a >= VRAM_BYTES || !vram_shadow.exists(a)) return 8'h00;
      return vram_shadow[a];
   endfunction

   // merge into first strictly overlapping slot, else append, else collapse
   function automatic void insert_rect(int unsigned l, int unsigned t,
                                       int unsigned r, int unsigned b);
      int unsigned ml, mt, mr, mb;
      ml = l; mt = t; mr = r; mb = b;
      for (int k = 0; k < rect_count; k++) begin
         if (rect_l[k] < r && rect_r[k] > l && rect_t[k] < b && rect_b[k] > t) begin
            if (l < rect_l[k]) rect_l[k] = l;
            if (t < rect_t[k]) rect_t[k] = t;
            if (r > rect_r[k]) rect_r[k] = r;
            if (b > rect_b[k]) rect_b[k] = b;
            return;
         end
      end
      if (rect_count < DIRTY_SLOTS) begin
         rect_l[rect_count] = l;
         rect_t[rect_count] = t;
         rect_r[rect_count] = r;
         rect_b[rect_count] = b;
         rect_count++;
         return;
      end
      for (int k = 0; k < DIRTY_SLOTS; k++) begin
         if (rect_l[k] < ml) ml = rect_l[k];
         if (rect_t[k] < mt) mt = rect_t[k];
         if (rect_r[k] > mr) mr = rect_r[k];
         if (rect_b[k] > mb) mb = rect_b[k];
      end
      rect_l[0] = ml; rect_t[0] = mt; rect_r[0] = mr; rect_b[0] = mb;
      rect_count = 1;
   endfunction

   function automatic vram_rsp_type vram_access(logic [1:0] op, logic [19:0] addr,
                                                logic [2:0] size_in, logic [31:0] wdata,
                                                logic [3:0] slot);
      vram_rsp_type res;
      int unsigned  size, n, offs, len, stride, row, col, take;
      res = '0;
      size = (size_in > MAX_SIZE) ? MAX_SIZE : size_in;
      case (op)
         OP_READ: begin
            for (int i = 0; i < size; i++)
               res.read_data = {res.read_data[23:0], vram_byte(addr + i)};
         end
         OP_WRITE: begin
            n = 0;
            for (int i = 0; i < size; i++) begin
               if (addr + i < VRAM_BYTES) begin
                  vram_shadow[addr + i] = wdata[8*(size-1-i) +: 8];
                  n++;
               end
            end
            // split the written prefix into one-row pieces
            stride = (stride_reg == 0) ? VRAM_BYTES : stride_reg;
            offs = addr;
            len = n;
            while (len > 0) begin
               row = offs / stride;
               col = offs % stride;
               take = stride - col;
               if (take > len) take = len;
               insert_rect(col, row, col + take, row + 1);
               offs += take;
               len -= take;
            end
         end
         OP_PEEK: begin
            if (slot < rect_count) begin
               res.left   = COORD_W'(rect_l[slot]);
               res.top    = COORD_W'(rect_t[slot]);
               res.right  = COORD_W'(rect_r[slot]);
               res.bottom = COORD_W'(rect_b[slot]);
            end
         end
         default: ;
      endcase
      res.dirty_total = 5'(rect_count);
      return res;
   endfunction

   always @(posedge clock) begin
      vram_rsp_type exp_rsp;
      if (reset) begin
         vram_shadow.delete();
         rect_count = 0;
         stride_reg = 0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transaction with nothing expected");
               fail_count++;
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (rsp_read_data !== exp_rsp.read_data) begin
                  $error("read_data exp %h got %h", exp_rsp.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_dirty_total !== exp_rsp.dirty_total) begin
                  $error("dirty_total exp %0d got %0d", exp_rsp.dirty_total,
                         rsp_dirty_total);
                  fail_count++;
               end
               if (rsp_rect_left !== exp_rsp.left) begin
                  $error("rect_left exp %0d got %0d", exp_rsp.left, rsp_rect_left);
                  fail_count++;
               end
               if (rsp_rect_top !== exp_rsp.top) begin
                  $error("rect_top exp %0d got %0d", exp_rsp.top, rsp_rect_top);
                  fail_count++;
               end
               if (rsp_rect_right !== exp_rsp.right) begin
                  $error("rect_right exp %0d got %0d", exp_rsp.right, rsp_rect_right);
                  fail_count++;
               end
               if (rsp_rect_bottom !== exp_rsp.bottom) begin
                  $error("rect_bottom exp %0d got %0d", exp_rsp.bottom, rsp_rect_bottom);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable) stride_reg = csr_write_data;
         if (req_valid && req_ready)
            expected_rsp.push_back(vram_access(req_opcode, req_address, req_access_size,
                                               req_write_data, req_slot_index));
      end
      pending = expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

>>> bench/vram_dirty_rect_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vram_dirty_rect_tracker_tb
// Drives directed and random reads, writes and peeks under several row
// strides, with random stalls on both channels; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module vram_dirty_rect_tracker_tb;
   import vdrt_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int STALL_LIMIT = 5000000;   // covers the post-reset clearing pass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [19:0] req_address;
   logic [2:0]  req_access_size;
   logic [31:0] req_write_data;
   logic [3:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [4:0]  rsp_dirty_total;
   logic [20:0] rsp_rect_left;
   logic [20:0] rsp_rect_top;
   logic [20:0] rsp_rect_right;
   logic [20:0] rsp_rect_bottom;
   logic        csr_write_enable;
   logic [20:0] csr_write_data;
   int          fail_count;
   int          pending;
   bit          no_idle;
   bit          hold_req;
   logic [19:0] window_base;

   vram_dirty_rect_tracker u_top (.*);

   vram_dirty_rect_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls, plus one long response hold-off set by hold_req
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 33);
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic [1:0] op, logic [19:0] addr, logic [2:0] size,
                            logic [31:0] wdata, logic [3:0] slot);
      while (!no_idle && $urandom_range(99) < 33) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_address = addr;
      req_access_size = size;
      req_write_data = wdata;
      req_slot_index = slot;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_valid = 1'b0;
      wait (pending == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_stride(logic [20:0] value);
      drain_all();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_items(int count);
      logic [1:0]  op;
      logic [19:0] addr;
      logic [2:0]  size;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         op = (pick < 40) ? OP_WRITE : (pick < 70) ? OP_READ :
              (pick < 95) ? OP_PEEK : OP_NONE;
         pick = $urandom_range(99);
         // mostly a small window so reads hit written bytes and rects overlap
         addr = (pick < 70) ? window_base + 20'($urandom_range(255)) :
                (pick < 80) ? 20'hFFFFF - 20'($urandom_range(3)) : 20'($urandom);
         size = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) :
                3'($urandom_range(7));
         send_item(op, addr, size, $urandom, 4'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      no_idle = 1'b0;
      hold_req = 1'b0;
      window_base = 20'h0;
      req_valid = 1'b0;
      req_opcode = OP_READ;
      req_address = '0;
      req_access_size = '0;
      req_write_data = '0;
      req_slot_index = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every opcode, odd sizes, partial writes, empty peeks
      send_item(OP_PEEK, 20'h0, 3'd1, 32'h0, 4'd0);
      send_item(OP_READ, 20'h0, 3'd4, 32'h0, 4'd0);
      send_item(OP_WRITE, 20'h0, 3'd4, 32'hDEADBEEF, 4'd15);
      send_item(OP_READ, 20'h0, 3'd4, 32'h0, 4'd0);
      send_item(OP_WRITE, 20'h2, 3'd4, 32'hFFFFFFFF, 4'd0);
      send_item(OP_WRITE, 20'h100, 3'd0, 32'h12345678, 4'd0);
      send_item(OP_WRITE, 20'h200, 3'd7, 32'hA5A55A5A, 4'd0);
      send_item(OP_READ, 20'h200, 3'd5, 32'h0, 4'd0);
      send_item(OP_READ, 20'h0, 3'd0, 32'h0, 4'd0);
      send_item(OP_WRITE, 20'hFFFFE, 3'd4, 32'h11223344, 4'd0);
      send_item(OP_WRITE, 20'hFFFFF, 3'd6, 32'h55667788, 4'd0);
      send_item(OP_READ, 20'hFFFFD, 3'd4, 32'h0, 4'd0);
      send_item(OP_READ, 20'hFFFFF, 3'd4, 32'h0, 4'd0);
      send_item(OP_NONE, 20'hFFFFF, 3'd7, 32'hFFFFFFFF, 4'd15);
      for (int s = 0; s < 4; s++) send_item(OP_PEEK, 20'h0, 3'd0, 32'h0, 4'(s));
      send_item(OP_PEEK, 20'hFFFFF, 3'd7, 32'h0, 4'd15);

      set_stride(21'd1);
      send_item(OP_WRITE, 20'h10, 3'd4, 32'h01020304, 4'd0);
      send_item(OP_PEEK, 20'h0, 3'd1, 32'h0, 4'd3);
      random_items(90);

      set_stride(21'd1048576);
      window_base = 20'h40000;
      no_idle = 1'b1;
      random_items(100);
      no_idle = 1'b0;

      set_stride(21'd3);
      window_base = 20'h80000;
      hold_req = 1'b1;
      random_items(100);

      set_stride(21'd64);
      window_base = 20'hC0000;
      random_items(100);

      set_stride(21'd0);
      window_base = 20'h1000;
      random_items(100);

      set_stride(21'($urandom_range(1048576, 1)));
      window_base = 20'($urandom);
      random_items(100);

      drain_all();
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/vdrt_pkg.sv
rtl/core/vdrt_vram.sv
rtl/core/vdrt_divider.sv
rtl/core/vdrt_datapath.sv
rtl/core/vdrt_ctrl.sv
rtl/core/vram_dirty_rect_tracker.sv
bench/vram_dirty_rect_checker.sv
bench/vram_dirty_rect_tracker_tb.sv
